// File: design/imm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

	// Store bounds
	localparam int MAX_ROWS_A = 4;
	localparam int MAX_INNER  = 4;
	localparam int MAX_COLS_B = 4;

	// Field widths
	localparam int CFG_W = 3;
	localparam int IDX_W = 2;
	localparam int VAL_W = 16;
	localparam int SUM_W = 32;
	localparam int CMD_W = 2;

	localparam int IN_FIELDS_W  = 2 * IDX_W + VAL_W;
	localparam int S_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * IDX_W + SUM_W;
	localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

	function automatic int clog2p(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	localparam int A_DEPTH = MAX_ROWS_A * MAX_INNER;
	localparam int B_DEPTH = MAX_INNER * MAX_COLS_B;
	localparam int A_AW    = clog2p(A_DEPTH);
	localparam int B_AW    = clog2p(B_DEPTH);
	localparam int ST_AW   = (A_AW > B_AW) ? A_AW : B_AW;

	// Loop counter widths
	localparam int RI_W = clog2p(MAX_ROWS_A);
	localparam int KI_W = clog2p(MAX_INNER);
	localparam int CI_W = clog2p(MAX_COLS_B);

	// Effective sizes reach the bound itself (up to 4)
	localparam int DIM_W = 4;

	// Command queue
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = clog2p(Q_DEPTH);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_FLUSH,
		ST_EMIT
	} bstate_t;

	typedef struct packed {
		cmd_t                    op;
		logic [ST_AW-1:0]        addr;
		logic signed [VAL_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] inner;
		logic [DIM_W-1:0] cols;
	} dims_t;

	// Zero counts as one, anything above the bound as the bound
	function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_W-1:0] r, input int bound);
		logic [DIM_W-1:0] v;
		v = DIM_W'(r);
		if (r == '0)
			v = DIM_W'(1);
		else if (int'(r) > bound)
			v = DIM_W'(bound);
		return v;
	endfunction

endpackage

`default_nettype wire

// File: design/integer_matrix_multiply.sv
// Signed integer matrix multiplier. Each slave transfer carries a command in
// s_tuser: load one element of A, load one element of B (row, column and a
// signed 16-bit value in s_tdata), or compute. A compute command streams the
// product A*B out in row-major order, one master transfer per element, with
// row, column and a 32-bit sum that wraps like C int; m_tlast marks the final
// element. Sizes in use come from three config registers (rows_a, inner_dim,
// cols_b; 0 acts as 1, values above 4 act as 4), which must only be written
// while the block is idle. Loads outside the stores and the reserved command
// are dropped. Elements must be loaded before they are used; unwritten ones
// read as garbage. Commands go through a 4-entry queue, so the slave side
// keeps accepting while a result waits on the master side. Loads retire one
// per cycle while no compute is running. A compute runs through one shared
// multiplier that does store read, multiply and accumulate in a three-stage
// pipe, drained before each element goes to the output register; the queue
// stalls behind it until the compute ends. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_multiply (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// slave stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [imm_pkg::S_TDATA_W-1:0] s_tdata,  // row[1:0], col[3:2], value[19:4]
	input  wire logic [imm_pkg::CMD_W-1:0]     s_tuser,  // cmd[1:0]
	// master stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [imm_pkg::M_TDATA_W-1:0]      m_tdata,  // out_row[1:0], out_col[3:2], sum[35:4]
	output logic                               m_tlast,
	// config writes
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [imm_pkg::CFG_W-1:0]     cfg_data
);
	import imm_pkg::*;

	logic [CFG_W-1:0] rows_a_q;
	logic [CFG_W-1:0] inner_dim_q;
	logic [CFG_W-1:0] cols_b_q;
	dims_t            dims;

	logic  push;
	item_t push_item;
	logic  q_full;
	logic  pop;
	logic  head_valid;
	item_t head_item;

	// Config registers; an index past the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= CFG_W'(4);
			inner_dim_q <= CFG_W'(4);
			cols_b_q <= CFG_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_A:    rows_a_q <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_COLS_B:    cols_b_q <= cfg_data;
				default: begin
					rows_a_q <= rows_a_q;
				end
			endcase
		end
	end

	// Clamp sizes to the store bounds
	assign dims.rows = eff_size(rows_a_q, MAX_ROWS_A);
	assign dims.inner = eff_size(inner_dim_q, MAX_INNER);
	assign dims.cols = eff_size(cols_b_q, MAX_COLS_B);

	// Front: accept, classify, compute store address
	imm_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Command queue between front and back
	imm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// Back: stores, MAC sequencer, result register
	imm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.dims       (dims),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

// File: design/imm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module imm_front (
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [imm_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [imm_pkg::CMD_W-1:0]     s_tuser,
	input  wire logic                          q_full,
	output logic                               push,
	output imm_pkg::item_t                     push_item
);
	import imm_pkg::*;

	logic [IDX_W-1:0] row;
	logic [IDX_W-1:0] col;
	logic             keep;
	int               addr_a;
	int               addr_b;

	assign row = s_tdata[IDX_W-1:0];
	assign col = s_tdata[2*IDX_W-1:IDX_W];

	assign addr_a = int'(row) * MAX_INNER + int'(col);
	assign addr_b = int'(row) * MAX_COLS_B + int'(col);

	// Drop reserved commands and loads outside the stores
	always_comb begin
		keep = 1'b0;
		push_item.op = CMD_COMPUTE;
		push_item.addr = '0;
		push_item.value = s_tdata[IN_FIELDS_W-1:2*IDX_W];
		case (s_tuser)
			CMD_LOAD_A: begin
				keep = (int'(row) < MAX_ROWS_A) && (int'(col) < MAX_INNER);
				push_item.op = CMD_LOAD_A;
				push_item.addr = ST_AW'(addr_a);
			end
			CMD_LOAD_B: begin
				keep = (int'(row) < MAX_INNER) && (int'(col) < MAX_COLS_B);
				push_item.op = CMD_LOAD_B;
				push_item.addr = ST_AW'(addr_b);
			end
			CMD_COMPUTE: begin
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready = !q_full;
	assign push = s_tvalid && s_tready && keep;

endmodule

`default_nettype wire

// File: design/imm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module imm_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire imm_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output imm_pkg::item_t      head_item
);
	import imm_pkg::*;

	item_t           ent_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_pop;

	assign full = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item = ent_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: design/imm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module imm_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire imm_pkg::dims_t                dims,
	input  wire logic                          head_valid,
	input  wire imm_pkg::item_t                head_item,
	output logic                               pop,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [imm_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                               m_tlast
);
	import imm_pkg::*;

	logic signed [VAL_W-1:0] mem_a [A_DEPTH];
	logic signed [VAL_W-1:0] mem_b [B_DEPTH];

	bstate_t state_q, state_nx;

	dims_t           dims_q;
	logic [RI_W-1:0] i_q;
	logic [CI_W-1:0] j_q;
	logic [KI_W-1:0] k_q;

	logic [A_AW-1:0] ra_addr;
	logic [B_AW-1:0] rb_addr;

	logic                    v_s1;
	logic signed [VAL_W-1:0] a_s1;
	logic signed [VAL_W-1:0] b_s1;
	logic                    v_s2;
	logic [SUM_W-1:0]        prod_s2;
	logic [SUM_W-1:0]        acc_q;

	logic                 out_valid_q;
	logic [IDX_W-1:0]     out_row_q;
	logic [IDX_W-1:0]     out_col_q;
	logic [SUM_W-1:0]     out_sum_q;
	logic                 out_last_q;

	logic start;
	logic issue;
	logic emit;
	logic last_i;
	logic last_j;
	logic last_k;

	assign last_i = ((DIM_W'(i_q) + DIM_W'(1)) == dims_q.rows);
	assign last_j = ((DIM_W'(j_q) + DIM_W'(1)) == dims_q.cols);
	assign last_k = ((DIM_W'(k_q) + DIM_W'(1)) == dims_q.inner);

	assign ra_addr = A_AW'(int'(i_q) * MAX_INNER + int'(k_q));
	assign rb_addr = B_AW'(int'(k_q) * MAX_COLS_B + int'(j_q));

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && head_item.op == CMD_COMPUTE)
					state_nx = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (last_k)
					state_nx = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!v_s1 && !v_s2)
					state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || m_tready)
					state_nx = (last_i && last_j) ? ST_IDLE : ST_ISSUE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		pop = 1'b0;
		start = 1'b0;
		issue = 1'b0;
		emit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop = head_valid;
				start = head_valid && head_item.op == CMD_COMPUTE;
			end
			ST_ISSUE: begin
				issue = 1'b1;
			end
			ST_EMIT: begin
				emit = !out_valid_q || m_tready;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	// element stores
	always_ff @(posedge clk) begin
		if (pop && head_item.op == CMD_LOAD_A)
			mem_a[A_AW'(head_item.addr)] <= head_item.value;
		if (pop && head_item.op == CMD_LOAD_B)
			mem_b[B_AW'(head_item.addr)] <= head_item.value;
		a_s1 <= mem_a[ra_addr];
		b_s1 <= mem_b[rb_addr];
	end

	// loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (start) begin
				dims_q <= dims;
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end
			if (issue)
				k_q <= last_k ? '0 : k_q + 1'b1;
			if (emit) begin
				if (last_j) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	// multiply-accumulate pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// operands sign-extended before the multiply, low 32 bits kept
	always_ff @(posedge clk) begin
		prod_s2 <= SUM_W'(a_s1) * SUM_W'(b_s1);
		if (start || emit)
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + prod_s2;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row_q <= IDX_W'(i_q);
			out_col_q <= IDX_W'(j_q);
			out_sum_q <= acc_q;
			out_last_q <= last_i && last_j;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast = out_last_q;
	assign m_tdata = M_TDATA_W'({out_sum_q, out_col_q, out_row_q});

endmodule

`default_nettype wire

// File: design/imm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module imm_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [imm_pkg::S_TDATA_W-1:0] s_tdata,
	input wire logic [imm_pkg::CMD_W-1:0]     s_tuser,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [imm_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic                          m_tlast,
	input wire logic                          cfg_we,
	input wire logic [1:0]                    cfg_index,
	input wire logic [imm_pkg::CFG_W-1:0]     cfg_data
);
	import imm_pkg::*;

	logic [3:0] pending_q;
	logic       first_q;
	logic       comp_in;
	logic       run_done;
	logic       out_xfer;

	assign comp_in = s_tvalid && s_tready && s_tuser == CMD_COMPUTE;
	assign out_xfer = m_tvalid && m_tready;
	assign run_done = out_xfer && m_tlast;

	// Computes accepted but not yet finished; first element of a run pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			first_q <= 1'b1;
		end else begin
			if (comp_in && !run_done)
				pending_q <= pending_q + 1'b1;
			else if (!comp_in && run_done)
				pending_q <= pending_q - 1'b1;
			if (out_xfer)
				first_q <= m_tlast;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 4'd0)
		else $error("result without outstanding compute");

	a_first_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q |-> m_tdata[2*IDX_W-1:0] == '0)
		else $error("run does not start at row 0, column 0");

	a_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		comp_in && pending_q == 4'd0 |=> !m_tvalid)
		else $error("result appeared one cycle after compute");

	logic unused_ok;
	assign unused_ok = ^{s_tdata, cfg_we, cfg_index, cfg_data};

endmodule

bind integer_matrix_multiply imm_checker u_chk (.*);

`default_nettype wire
